FILE: rtl/vdp_pkg.sv
// Shared types, codes and helpers for the video display port block.
// Used by the controller, the datapath and the top level; depends on nothing.
package vdp_pkg;

    localparam int VRAM_DEPTH_DEF = 16384;
    localparam int CRAM_DEPTH_DEF = 32;
    localparam int ADDR_W = 14;

    // Port access kinds.
    localparam logic [1:0] KIND_CTL = 2'd0;
    localparam logic [1:0] KIND_WR  = 2'd1;
    localparam logic [1:0] KIND_RD  = 2'd2;

    // Access codes held in the top two bits of the control word.
    localparam logic [1:0] CODE_READ = 2'd0;
    localparam logic [1:0] CODE_REG  = 2'd2;
    localparam logic [1:0] CODE_CRAM = 2'd3;

    // Memory targets reported with a beat.
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_VRAM = 2'd1;
    localparam logic [1:0] TGT_CRAM = 2'd2;

    // Register indexes.
    localparam logic [3:0] REG_MODE_ONE = 4'd0;
    localparam logic [3:0] REG_MODE_TWO = 4'd1;
    localparam logic [3:0] REG_NAME     = 4'd2;
    localparam logic [3:0] REG_COLOR    = 4'd3;
    localparam logic [3:0] REG_PATTERN  = 4'd4;
    localparam logic [3:0] REG_SPR_ATTR = 4'd5;
    localparam logic [3:0] REG_SPR_PAT  = 4'd6;
    localparam logic [3:0] REG_BYTE_0   = 4'd7;
    localparam logic [3:0] REG_BYTE_1   = 4'd8;
    localparam logic [3:0] REG_BYTE_2   = 4'd9;
    localparam logic [3:0] REG_BYTE_3   = 4'd10;
    localparam logic [3:0] REG_NONE     = 4'd15;

    // Decoded mode values.
    localparam logic [3:0] MODE_TEXT    = 4'h1;
    localparam logic [3:0] MODE_GFX_TWO = 4'h2;
    localparam logic [3:0] MODE_ALIAS_A = 4'h9;
    localparam logic [3:0] MODE_ALIAS_B = 4'hd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUTE,
        ST_MOD,
        ST_MEM,
        ST_WAIT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic load_ctl;
        logic mod_start;
        logic mod_step;
        logic mem_go;
        logic buf_load;
        logic reg_go;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_fetch;
        logic need_write;
        logic need_reg;
        logic mod_done;
    } ctrl_status_t;

    function automatic logic [3:0] decode_mode(input logic [7:0] m1, input logic [7:0] m2);
        logic [3:0] m;
        m = {m1[2], m2[3], m1[1], m2[4]};
        if (m == MODE_ALIAS_A || m == MODE_ALIAS_B) begin
            m = MODE_TEXT;
        end
        return m;
    endfunction

endpackage

FILE: rtl/vdp_ram.sv
// Generic single-port RAM with a registered read.
// Stand-alone; no package needed.
module vdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem_reg[addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/vdp_ctrl.sv
// Sequencer for one port access: load, route, address reduction, memory, buffer load, beat.
// Depends on vdp_pkg for the state type and the command and status structs.
module vdp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  vdp_pkg::ctrl_status_t status,
    output vdp_pkg::ctrl_cmd_t    cmd,
    output logic                  busy,
    output logic                  done
);
    import vdp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_ROUTE;
            end
            ST_ROUTE:
            begin
                if (status.need_fetch || status.need_write)
                begin
                    state_next = ST_MOD;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_MOD:
            begin
                if (status.mod_done)
                begin
                    state_next = ST_MEM;
                end
            end
            ST_MEM:
            begin
                state_next = status.need_fetch ? ST_WAIT : ST_RESP;
            end
            ST_WAIT:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = start ? ST_LOAD : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The beat cycle also takes the next access, so busy drops there too.
    assign free = (state_reg == ST_IDLE) || (state_reg == ST_RESP);

    always_comb
    begin
        cmd          = '0;
        cmd.latch_in = start && free;
        busy         = !free;
        done         = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.load_ctl = 1'b1;
            end
            ST_ROUTE:
            begin
                cmd.mod_start = status.need_fetch || status.need_write;
                cmd.reg_go    = status.need_reg;
            end
            ST_MOD:
            begin
                cmd.mod_step = !status.mod_done;
            end
            ST_MEM:
            begin
                cmd.mem_go = 1'b1;
            end
            ST_WAIT:
            begin
                cmd.buf_load = 1'b1;
            end
            ST_RESP:
            begin
                done = 1'b1;
            end
            default:
            begin
                cmd.load_ctl = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/vdp_datapath.sv
// Port state, register file, address reduction unit and both memories.
// Depends on vdp_pkg and vdp_ram; driven by commands from vdp_ctrl.
module vdp_datapath #(
    parameter int VRAM_DEPTH = vdp_pkg::VRAM_DEPTH_DEF,
    parameter int CRAM_DEPTH = vdp_pkg::CRAM_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  vdp_pkg::ctrl_cmd_t    cmd,
    output vdp_pkg::ctrl_status_t status,
    input  logic [1:0]            kind,
    input  logic [7:0]            data_byte,
    output logic [7:0]            read_data,
    output logic                  read_valid,
    output logic [1:0]            write_target,
    output logic [13:0]           write_address,
    output logic [3:0]            reg_index,
    output logic [13:0]           reg_value,
    output logic [3:0]            display_mode
);
    import vdp_pkg::*;

    localparam int VAW = $clog2(VRAM_DEPTH);
    localparam int CAW = $clog2(CRAM_DEPTH);

    // A power-of-two depth is a mask. Any other depth takes two steps: a
    // reciprocal multiplication gives the quotient, then the quotient times
    // the depth is subtracted from the address.
    localparam bit V_POW2 = (VRAM_DEPTH & (VRAM_DEPTH - 1)) == 0;
    localparam bit C_POW2 = (CRAM_DEPTH & (CRAM_DEPTH - 1)) == 0;
    localparam int RECIP_W = ADDR_W + 2;
    localparam int PROD_W = ADDR_W + RECIP_W;
    localparam int V_SHR = ADDR_W + VAW;
    localparam int C_SHR = ADDR_W + CAW;
    localparam logic [RECIP_W-1:0] V_RECIP =
        RECIP_W'(((1 << V_SHR) + VRAM_DEPTH - 1) / VRAM_DEPTH);
    localparam logic [RECIP_W-1:0] C_RECIP =
        RECIP_W'(((1 << C_SHR) + CRAM_DEPTH - 1) / CRAM_DEPTH);
    localparam int STEP_W = 2;
    localparam logic [STEP_W-1:0] STEP_QUOT = STEP_W'(2);
    localparam int V_STEPS = V_POW2 ? 0 : 2;
    localparam int C_STEPS = C_POW2 ? 0 : 2;
    localparam logic [ADDR_W-1:0] V_MASK = ADDR_W'(VRAM_DEPTH - 1);
    localparam logic [ADDR_W-1:0] C_MASK = ADDR_W'(CRAM_DEPTH - 1);
    localparam logic [ADDR_W-1:0] V_DEPTH_L = ADDR_W'(VRAM_DEPTH);
    localparam logic [ADDR_W-1:0] C_DEPTH_L = ADDR_W'(CRAM_DEPTH);

    logic [1:0]        kind_reg;
    logic [7:0]        byte_reg;
    logic [15:0]       cw_reg;
    logic [15:0]       cw_next;
    logic              flag_reg;
    logic [13:0]       addr_reg;
    logic [1:0]        code_reg;
    logic [7:0]        rbuf_reg;
    logic [7:0]        mode_one_reg;
    logic [7:0]        mode_two_reg;
    logic [3:0]        mode_reg;
    logic [13:0]       bases_reg [5];
    logic [7:0]        bytes_reg [4];

    logic [13:0]       rem_reg;
    logic [ADDR_W-1:0] quo_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [PROD_W-1:0] quo_prod;
    logic [ADDR_W-1:0] quo_next;
    logic [2*ADDR_W-1:0] back_prod;

    logic [7:0]        rdata_reg;
    logic              rvalid_reg;
    logic [1:0]        target_reg;
    logic [13:0]       waddr_reg;
    logic [3:0]        ridx_reg;
    logic [13:0]       rval_reg;

    logic              sel_cram;
    logic [3:0]        reg_sel;
    logic [7:0]        reg_lo;
    logic [13:0]       reg_val;
    logic              reg_ok;
    logic [3:0]        base_off;
    logic [3:0]        byte_off;
    logic              vram_en;
    logic              vram_we;
    logic              cram_we;
    logic [7:0]        vram_rd;

    assign cw_next = flag_reg ? {byte_reg, cw_reg[7:0]} : {cw_reg[15:8], byte_reg};
    assign sel_cram = (kind_reg == KIND_WR) && (code_reg == CODE_CRAM);

    assign status.need_write = (kind_reg == KIND_WR);
    assign status.need_fetch = (kind_reg == KIND_RD)
        || ((kind_reg == KIND_CTL) && !flag_reg && (code_reg == CODE_READ));
    assign status.need_reg = (kind_reg == KIND_CTL) && !flag_reg && (code_reg == CODE_REG);
    assign status.mod_done = (cnt_reg == '0);

    assign reg_sel  = cw_reg[11:8];
    assign reg_lo   = cw_reg[7:0];
    assign base_off = reg_sel - REG_NAME;
    assign byte_off = reg_sel - REG_BYTE_0;

    always_comb
    begin
        reg_ok  = 1'b1;
        reg_val = {6'd0, reg_lo};
        case (reg_sel)
            REG_MODE_ONE, REG_MODE_TWO:
            begin
                reg_val = {6'd0, reg_lo};
            end
            REG_NAME:
            begin
                reg_val = {reg_lo[3:0], 10'd0};
            end
            REG_COLOR:
            begin
                reg_val = (mode_reg == MODE_GFX_TWO) ? {reg_lo[7], 13'd0} : {reg_lo, 6'd0};
            end
            REG_PATTERN:
            begin
                reg_val = mode_reg[1] ? {reg_lo[2], 13'd0} : {reg_lo[2:0], 11'd0};
            end
            REG_SPR_ATTR:
            begin
                reg_val = {reg_lo[6:1], 8'd0};
            end
            REG_SPR_PAT:
            begin
                reg_val = mode_reg[3] ? {reg_lo[2], 13'd0} : {reg_lo[2:0], 11'd0};
            end
            REG_BYTE_0, REG_BYTE_1, REG_BYTE_2, REG_BYTE_3:
            begin
                reg_val = {6'd0, reg_lo};
            end
            default:
            begin
                reg_ok  = 1'b0;
                reg_val = '0;
            end
        endcase
    end

    // Input capture and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            kind_reg   <= kind;
            byte_reg   <= data_byte;
            rdata_reg  <= '0;
            rvalid_reg <= 1'b0;
            target_reg <= TGT_NONE;
            waddr_reg  <= '0;
            ridx_reg   <= REG_NONE;
            rval_reg   <= '0;
        end
        if (cmd.mem_go)
        begin
            waddr_reg <= rem_reg;
            if (kind_reg == KIND_WR)
            begin
                target_reg <= sel_cram ? TGT_CRAM : TGT_VRAM;
            end
            if (kind_reg == KIND_RD)
            begin
                rdata_reg  <= rbuf_reg;
                rvalid_reg <= 1'b1;
            end
        end
        if (cmd.reg_go && reg_ok)
        begin
            ridx_reg <= reg_sel;
            rval_reg <= reg_val;
        end
    end

    assign quo_prod = {{(PROD_W - ADDR_W){1'b0}}, rem_reg}
        * {{(PROD_W - RECIP_W){1'b0}}, (sel_cram ? C_RECIP : V_RECIP)};
    assign quo_next = sel_cram ? ADDR_W'(quo_prod >> C_SHR) : ADDR_W'(quo_prod >> V_SHR);
    assign back_prod = {{ADDR_W{1'b0}}, quo_reg}
        * {{ADDR_W{1'b0}}, (sel_cram ? C_DEPTH_L : V_DEPTH_L)};

    // Address reduction unit: quotient first, then the remainder.
    always_ff @(posedge clk)
    begin
        if (cmd.mod_start)
        begin
            if (sel_cram)
            begin
                rem_reg <= C_POW2 ? (addr_reg & C_MASK) : addr_reg;
            end
            else
            begin
                rem_reg <= V_POW2 ? (addr_reg & V_MASK) : addr_reg;
            end
        end
        else if (cmd.mod_step)
        begin
            if (cnt_reg == STEP_QUOT)
            begin
                quo_reg <= quo_next;
            end
            else
            begin
                rem_reg <= rem_reg - back_prod[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            cw_reg       <= '0;
            flag_reg     <= 1'b0;
            addr_reg     <= '0;
            code_reg     <= CODE_READ;
            rbuf_reg     <= '0;
            mode_one_reg <= '0;
            mode_two_reg <= '0;
            mode_reg     <= '0;
            for (int i = 0; i < 5; i++)
            begin
                bases_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                bytes_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.mod_start)
            begin
                cnt_reg <= sel_cram ? STEP_W'(C_STEPS) : STEP_W'(V_STEPS);
            end
            else if (cmd.mod_step)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end

            if (cmd.load_ctl)
            begin
                case (kind_reg)
                    KIND_CTL:
                    begin
                        cw_reg   <= cw_next;
                        flag_reg <= !flag_reg;
                        addr_reg <= cw_next[13:0];
                        code_reg <= cw_next[15:14];
                    end
                    KIND_WR, KIND_RD:
                    begin
                        flag_reg <= 1'b0;
                    end
                    default:
                    begin
                        flag_reg <= flag_reg;
                    end
                endcase
            end

            if (cmd.mem_go)
            begin
                addr_reg <= addr_reg + 1'b1;
                if (kind_reg == KIND_WR)
                begin
                    rbuf_reg <= byte_reg;
                end
            end

            if (cmd.buf_load)
            begin
                rbuf_reg <= vram_rd;
            end

            if (cmd.reg_go)
            begin
                case (reg_sel)
                    REG_MODE_ONE:
                    begin
                        mode_one_reg <= reg_lo;
                        mode_reg     <= decode_mode(reg_lo, mode_two_reg);
                    end
                    REG_MODE_TWO:
                    begin
                        mode_two_reg <= reg_lo;
                        mode_reg     <= decode_mode(mode_one_reg, reg_lo);
                    end
                    REG_NAME, REG_COLOR, REG_PATTERN, REG_SPR_ATTR, REG_SPR_PAT:
                    begin
                        bases_reg[base_off[2:0]] <= reg_val;
                    end
                    REG_BYTE_0, REG_BYTE_1, REG_BYTE_2, REG_BYTE_3:
                    begin
                        bytes_reg[byte_off[1:0]] <= reg_lo;
                    end
                    default:
                    begin
                        mode_reg <= mode_reg;
                    end
                endcase
            end
        end
    end

    assign vram_en = cmd.mem_go && !sel_cram;
    assign vram_we = cmd.mem_go && (kind_reg == KIND_WR) && !sel_cram;
    assign cram_we = cmd.mem_go && sel_cram;

    vdp_ram #(
        .WIDTH (8),
        .DEPTH (VRAM_DEPTH)
    ) u_vram (
        .clk     (clk),
        .en      (vram_en),
        .we      (vram_we),
        .addr    (rem_reg[VAW-1:0]),
        .wr_data (byte_reg),
        .rd_data (vram_rd)
    );

    // Color memory is write-only from the port side.
    vdp_ram #(
        .WIDTH (8),
        .DEPTH (CRAM_DEPTH)
    ) u_cram (
        .clk     (clk),
        .en      (cram_we),
        .we      (cram_we),
        .addr    (rem_reg[CAW-1:0]),
        .wr_data (byte_reg),
        .rd_data ()
    );

    assign read_data     = rdata_reg;
    assign read_valid    = rvalid_reg;
    assign write_target  = target_reg;
    assign write_address = waddr_reg;
    assign reg_index     = ridx_reg;
    assign reg_value     = rval_reg;
    assign display_mode  = mode_reg;

endmodule

FILE: rtl/vdp_control_data_port.sv
// Control and data port of a video display processor. Each access passes load and route;
// control bytes and register writes then strobe done, data writes first pass address
// reduction and memory, and reads and pre-fetches also the buffer load. Reduction takes a
// quotient and a remainder step for a depth that is not a power of two. A new access is
// taken in the strobe cycle. Asynchronous reset clears the controller, port state and
// register file, not the captured inputs, results or memories. The receiver cannot stall.
module vdp_control_data_port #(
    parameter int VRAM_DEPTH = vdp_pkg::VRAM_DEPTH_DEF,
    parameter int CRAM_DEPTH = vdp_pkg::CRAM_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    output logic [7:0]  read_data,
    output logic        read_valid,
    output logic [1:0]  write_target,
    output logic [13:0] write_address,
    output logic [3:0]  reg_index,
    output logic [13:0] reg_value,
    output logic [3:0]  display_mode
);
    import vdp_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    vdp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    vdp_datapath #(
        .VRAM_DEPTH (VRAM_DEPTH),
        .CRAM_DEPTH (CRAM_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .kind          (kind),
        .data_byte     (data_byte),
        .read_data     (read_data),
        .read_valid    (read_valid),
        .write_target  (write_target),
        .write_address (write_address),
        .reg_index     (reg_index),
        .reg_value     (reg_value),
        .display_mode  (display_mode)
    );

endmodule

FILE: bench/tb.sv
// Self-checking bench for the control and data port of the video display processor.
// Needs vdp_pkg and vdp_control_data_port. A shadow model of the port predicts each beat,
// and the bench compares it with the block field by field under random start gaps.
module tb;
    import vdp_pkg::*;

    localparam int VRAM_WORDS = VRAM_DEPTH_DEF;
    localparam int CRAM_WORDS = CRAM_DEPTH_DEF;
    localparam int ITEM_TARGET = 1800;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam logic [1:0] CODE_WRITE = 2'd1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } port_access_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        read_valid;
        logic [1:0]  write_target;
        logic [13:0] write_address;
        logic [3:0]  reg_index;
        logic [13:0] reg_value;
        logic [3:0]  display_mode;
    } port_beat_t;

    typedef struct packed {
        logic         drain;
        port_access_t acc;
        port_beat_t   beat;
    } planned_access_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  kind = '0;
    logic [7:0]  data_byte = '0;
    logic        busy;
    logic        done;
    logic [7:0]  read_data;
    logic        read_valid;
    logic [1:0]  write_target;
    logic [13:0] write_address;
    logic [3:0]  reg_index;
    logic [13:0] reg_value;
    logic [3:0]  display_mode;

    vdp_control_data_port dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .done          (done),
        .kind          (kind),
        .data_byte     (data_byte),
        .read_data     (read_data),
        .read_valid    (read_valid),
        .write_target  (write_target),
        .write_address (write_address),
        .reg_index     (reg_index),
        .reg_value     (reg_value),
        .display_mode  (display_mode)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow state of the port.
    logic [15:0] ctl_word = '0;
    logic        second_byte = 1'b0;
    logic [13:0] acc_addr = '0;
    logic [1:0]  acc_code = '0;
    logic [7:0]  rd_buf = '0;
    logic [7:0]  mode_one = '0;
    logic [7:0]  mode_two = '0;
    logic [3:0]  cur_mode = '0;
    logic [7:0]  vram [VRAM_WORDS];
    bit          vram_written [VRAM_WORDS];

    planned_access_t access_queue[$];
    port_beat_t      expected_beats[$];
    planned_access_t in_flight;
    int              planned = 0;
    int              total_items = 0;
    int              sent = 0;
    int              gap_left = 0;
    bit              drain_next = 1'b0;
    int              mismatches = 0;
    int              cycle_count = 0;
    int              n_beats = 0;
    int              n_reads = 0;
    int              n_vram = 0;
    int              n_cram = 0;
    int              n_regs = 0;

    function automatic port_beat_t predict_access(port_access_t a);
        port_beat_t r;
        logic [7:0]  lo;
        logic [3:0]  ridx;
        logic [13:0] v;
        logic [3:0]  m;
        int          slot;
        r = '0;
        r.reg_index = REG_NONE;
        v = '0;
        case (a.kind)
            KIND_CTL:
            begin
                if (second_byte)
                    ctl_word[15:8] = a.data_byte;
                else
                    ctl_word[7:0] = a.data_byte;
                second_byte = !second_byte;
                acc_addr = ctl_word[13:0];
                acc_code = ctl_word[15:14];
                if (!second_byte && acc_code == CODE_READ)
                begin
                    slot = acc_addr % VRAM_WORDS;
                    r.write_address = 14'(slot);
                    rd_buf = vram[slot];
                    acc_addr = acc_addr + 1'b1;
                end
                else if (!second_byte && acc_code == CODE_REG)
                begin
                    lo = ctl_word[7:0];
                    ridx = ctl_word[11:8];
                    case (ridx)
                        REG_MODE_ONE:
                        begin
                            mode_one = lo;
                            v = {6'b0, lo};
                        end
                        REG_MODE_TWO:
                        begin
                            mode_two = lo;
                            v = {6'b0, lo};
                        end
                        REG_NAME:     v = {lo[3:0], 10'b0};
                        REG_COLOR:    v = (cur_mode == MODE_GFX_TWO) ? {lo[7], 13'b0} : {lo, 6'b0};
                        REG_PATTERN:  v = cur_mode[1] ? {lo[2], 13'b0} : {lo[2:0], 11'b0};
                        REG_SPR_ATTR: v = {lo[6:1], 8'b0};
                        REG_SPR_PAT:  v = cur_mode[3] ? {lo[2], 13'b0} : {lo[2:0], 11'b0};
                        REG_BYTE_0, REG_BYTE_1, REG_BYTE_2, REG_BYTE_3: v = {6'b0, lo};
                        default:      ridx = REG_NONE;
                    endcase
                    r.reg_index = ridx;
                    r.reg_value = v;
                    // Two of the sixteen bit patterns fold back onto the text mode.
                    m = {mode_one[2], mode_two[3], mode_one[1], mode_two[4]};
                    cur_mode = (m == MODE_ALIAS_A || m == MODE_ALIAS_B) ? MODE_TEXT : m;
                end
            end
            KIND_WR:
            begin
                if (acc_code != CODE_CRAM)
                begin
                    slot = acc_addr % VRAM_WORDS;
                    vram[slot] = a.data_byte;
                    vram_written[slot] = 1'b1;
                    r.write_target = TGT_VRAM;
                end
                else
                begin
                    slot = acc_addr % CRAM_WORDS;
                    r.write_target = TGT_CRAM;
                end
                r.write_address = 14'(slot);
                acc_addr = acc_addr + 1'b1;
                rd_buf = a.data_byte;
                second_byte = 1'b0;
            end
            KIND_RD:
            begin
                slot = acc_addr % VRAM_WORDS;
                r.read_data = rd_buf;
                r.read_valid = 1'b1;
                r.write_address = 14'(slot);
                rd_buf = vram[slot];
                acc_addr = acc_addr + 1'b1;
                second_byte = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.display_mode = cur_mode;
        return r;
    endfunction

    // True when the access would fetch a video memory byte that was never written.
    function automatic bit reads_blank(port_access_t a);
        logic [13:0] target;
        target = {a.data_byte[5:0], ctl_word[7:0]};
        if (a.kind == KIND_RD)
            return !vram_written[acc_addr % VRAM_WORDS];
        if (a.kind == KIND_CTL && second_byte && a.data_byte[7:6] == CODE_READ)
            return !vram_written[target % VRAM_WORDS];
        return 1'b0;
    endfunction

    task automatic queue_access(logic [1:0] k, logic [7:0] b);
        port_access_t    a;
        planned_access_t p;
        a.kind = k;
        a.data_byte = b;
        if (reads_blank(a))
        begin
            // Turn a blank read into a write, and a blank pre-fetch into a write setup.
            if (k == KIND_RD)
                a.kind = KIND_WR;
            else
                a.data_byte[6] = 1'b1;
        end
        p.drain = drain_next;
        drain_next = 1'b0;
        p.acc = a;
        p.beat = predict_access(a);
        access_queue.push_back(p);
        if (a.kind != KIND_NONE)
            planned++;
    endtask

    task automatic point_at(logic [1:0] code, logic [13:0] addr);
        if (second_byte)
            queue_access(KIND_WR, 8'($urandom));
        queue_access(KIND_CTL, addr[7:0]);
        queue_access(KIND_CTL, {code, addr[13:8]});
    endtask

    task automatic load_register(logic [3:0] idx, logic [7:0] value);
        point_at(CODE_REG, {2'($urandom), idx, value});
    endtask

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    initial
    begin : stimulus
        int          n;
        int          next_drain;
        logic [13:0] last_base;
        logic [3:0]  idx;

        // Directed opening: wrap of the address at both ends, every access kind,
        // color memory, the byte flag dropped by a data access, and the
        // mode-dependent register decoding.
        point_at(CODE_WRITE, 14'h3ffe);
        queue_access(KIND_WR, 8'h00);
        queue_access(KIND_WR, 8'hff);
        queue_access(KIND_WR, 8'ha5);
        point_at(CODE_READ, 14'h3ffe);
        queue_access(KIND_RD, 8'h00);
        queue_access(KIND_RD, 8'hff);
        queue_access(KIND_NONE, 8'hff);
        point_at(CODE_CRAM, 14'h3fff);
        queue_access(KIND_WR, 8'h5a);
        queue_access(KIND_CTL, 8'h12);
        queue_access(KIND_WR, 8'h3c);
        load_register(REG_MODE_ONE, 8'h02);
        load_register(REG_COLOR, 8'hff);
        load_register(REG_MODE_ONE, 8'h04);
        load_register(REG_SPR_PAT, 8'hff);
        load_register(REG_MODE_TWO, 8'h10);
        load_register(REG_NONE, 8'h00);

        last_base = 14'h3ffe;
        next_drain = 300;
        while (planned < ITEM_TARGET)
        begin
            if (planned >= next_drain)
            begin
                drain_next = 1'b1;
                next_drain += 400;
            end
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    last_base = $urandom_range(0, 1) ? 14'($urandom)
                                                     : last_base + 14'($urandom_range(1, 64));
                    point_at(2'($urandom_range(0, 2)), last_base);
                    repeat ($urandom_range(1, 16)) queue_access(KIND_WR, 8'($urandom));
                end
                3, 4:
                begin
                    point_at(CODE_READ, last_base + 14'($urandom_range(0, 1)));
                    repeat ($urandom_range(1, 8)) queue_access(KIND_RD, 8'($urandom));
                end
                5:
                begin
                    point_at(CODE_CRAM, 14'($urandom));
                    repeat ($urandom_range(1, 8)) queue_access(KIND_WR, 8'($urandom));
                end
                6, 7:
                begin
                    idx = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 1))
                                                      : 4'($urandom_range(0, 15));
                    load_register(idx, 8'($urandom));
                end
                8:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 15) == 0)
                            queue_access(KIND_NONE, 8'($urandom));
                        else
                            queue_access(2'($urandom_range(0, 2)), 8'($urandom));
                    end
                end
                default:
                begin
                    repeat ($urandom_range(1, 8))
                        queue_access($urandom_range(0, 1) ? KIND_WR : KIND_RD, 8'($urandom));
                end
            endcase
        end
        total_items = access_queue.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (access_queue.size() != 0 || start)
            @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Checked %0d beats: %0d reads, %0d video memory writes, %0d color writes,",
                 n_beats, n_reads, n_vram, n_cram);
        $display("and %0d register loads, with random start gaps and drain pauses.", n_regs);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin : driver
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_beats.push_back(in_flight.beat);
                sent++;
            end
            if (!start || !busy)
            begin
                if (gap_left != 0)
                begin
                    start <= 1'b0;
                    gap_left--;
                end
                else if (access_queue.size() == 0
                         || (access_queue[0].drain && expected_beats.size() != 0))
                begin
                    start <= 1'b0;
                end
                else if (sent < total_items * 9 / 10 && (sent / 150) % 4 != 3
                         && $urandom_range(0, 9) == 0)
                begin
                    // This cycle opens a burst of idle cycles; gap_left counts the rest of it.
                    start <= 1'b0;
                    gap_left = $urandom_range(0, 15);
                end
                else
                begin
                    in_flight = access_queue.pop_front();
                    start <= 1'b1;
                    kind <= in_flight.acc.kind;
                    data_byte <= in_flight.acc.data_byte;
                end
            end
        end
    end

    // Results are sampled mid-cycle, away from the edge where the driver queues beats.
    always @(negedge clk)
    begin : monitor
        port_beat_t got;
        port_beat_t want;
        if (rst_n && done)
        begin
            got = {read_data, read_valid, write_target, write_address,
                   reg_index, reg_value, display_mode};
            n_beats++;
            if (expected_beats.size() == 0)
            begin
                $error("result beat with no access outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_beats.pop_front();
                check_field("read_data", 16'(want.read_data), 16'(got.read_data));
                check_field("read_valid", 16'(want.read_valid), 16'(got.read_valid));
                check_field("write_target", 16'(want.write_target), 16'(got.write_target));
                check_field("write_address", 16'(want.write_address),
                            16'(got.write_address));
                check_field("reg_index", 16'(want.reg_index), 16'(got.reg_index));
                check_field("reg_value", 16'(want.reg_value), 16'(got.reg_value));
                check_field("display_mode", 16'(want.display_mode), 16'(got.display_mode));
                if (want.read_valid)
                    n_reads++;
                if (want.write_target == TGT_VRAM)
                    n_vram++;
                if (want.write_target == TGT_CRAM)
                    n_cram++;
                if (want.reg_index != REG_NONE)
                    n_regs++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d beats outstanding",
                     cycle_count, expected_beats.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
